[hdl/qmc_pkg.sv]
// ----------------------------------------------------------------------------
// qmc_pkg: shared types and constants of the quantile mapping corrector
// Item structs, result status codes and the controller to datapath signals.
// ----------------------------------------------------------------------------
package qmc_pkg;

    localparam int MAX_POINTS_DEF = 128;
    localparam logic [7:0] POINTS_RESET = 8'd100;
    localparam logic KIND_ADD = 1'b0;

    typedef struct packed {
        logic              kind;
        logic signed [31:0] obs_value;
        logic              obs_valid;
        logic signed [31:0] fcst_value;
        logic              fcst_valid;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [2:0]         status;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_INTERP   = 3'd0,
        ST_EQUAL    = 3'd1,
        ST_CLAMP_LO = 3'd2,
        ST_CLAMP_HI = 3'd3,
        ST_PASS     = 3'd4,
        ST_STORED   = 3'd5,
        ST_IGNORED  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        OP_REMOVE = 2'd0,
        OP_INSERT = 2'd1,
        OP_SEARCH = 2'd2
    } scan_op_t;

    typedef enum logic {
        LIST_OBS  = 1'b0,
        LIST_FCST = 1'b1
    } list_t;

    typedef enum logic [2:0] {
        RES_NONE    = 3'd0,
        RES_STORED  = 3'd1,
        RES_IGNORED = 3'd2,
        RES_PASS    = 3'd3,
        RES_CALC    = 3'd4
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     scan_start;
        scan_op_t scan_op;
        list_t    scan_list;
        logic     ring_rd;
        logic     drop;
        logic     store;
        logic     ord0;
        logic     ord1;
        logic     ord2;
        logic     mul;
        logic     div_start;
        res_sel_t res_sel;
        logic     emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_add;
        logic pair_ok;
        logic corr_pass;
        logic need_drop;
        logic scan_done;
        logic need_div;
        logic div_busy;
        logic out_free;
    } dp_stat_t;

endpackage

[hdl/qmc_div.sv]
// ----------------------------------------------------------------------------
// qmc_div: restoring divider
// Divides a 64-bit dividend by a 32-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module qmc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);
    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [63:0] quo_reg;
    logic [31:0] den_reg;
    logic [33:0] trial;

    assign trial = {1'b0, rem_reg, quo_reg[63]} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg[31:0];

endmodule

[hdl/qmc_dp.sv]
// ----------------------------------------------------------------------------
// qmc_dp: datapath of the quantile mapping corrector
// Window rings, sorted lists, list scan engine, interpolation and output beat.
// ----------------------------------------------------------------------------
module qmc_dp #(
    parameter int MAX_POINTS = qmc_pkg::MAX_POINTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  qmc_pkg::in_item_t   in_data,
    input  logic                out_ready,
    output logic                out_valid,
    output qmc_pkg::out_item_t  out_data,
    input  qmc_pkg::ctrl_cmd_t  cmd,
    output qmc_pkg::dp_stat_t   stat
);
    import qmc_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [7:0]          cfg_reg;
    in_item_t            item_reg;
    logic [CW-1:0]       count_reg;
    logic [IW-1:0]       oldest_reg;

    logic signed [31:0]  ring_obs [MAX_POINTS];
    logic signed [31:0]  ring_fcst [MAX_POINTS];
    logic signed [31:0]  sobs_mem [MAX_POINTS];
    logic signed [31:0]  sfcst_mem [MAX_POINTS];
    logic signed [31:0]  ring_obs_q;
    logic signed [31:0]  ring_fcst_q;
    logic signed [31:0]  sobs_q;
    logic signed [31:0]  sfcst_q;

    logic                active_reg;
    scan_op_t            op_reg;
    list_t               list_reg;
    logic [CW-1:0]       rd_idx_reg;
    logic                rv_reg;
    logic [IW-1:0]       dj_reg;
    logic                found_reg;
    logic signed [31:0]  hold_reg;
    logic signed [31:0]  prev_reg;
    logic [IW-1:0]       fi_reg;
    logic signed [31:0]  lf_reg;
    logic signed [31:0]  uf_reg;
    logic signed [31:0]  lo_reg;
    logic signed [31:0]  hi_reg;
    logic                dneg_reg;
    logic [63:0]         prod_reg;
    logic signed [31:0]  res_value_reg;
    status_t             res_status_reg;
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic [CW-1:0]       cap;
    logic [CW:0]         slot_sum;
    logic [CW:0]         slot_wrap;
    logic [IW-1:0]       slot;
    logic                scan_issue;
    logic                scan_done;
    logic [IW-1:0]       scan_addr;
    logic signed [31:0]  key;
    logic signed [31:0]  d;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic signed [31:0]  wr_data;
    logic [IW-1:0]       last_idx;
    logic [IW-1:0]       a0;
    logic [IW-1:0]       a1;
    logic [IW-1:0]       sobs_raddr;
    logic [32:0]         diff;
    logic [32:0]         ndiff;
    logic [31:0]         mag;
    logic [32:0]         num_w;
    logic [32:0]         den_w;
    logic [63:0]         prod_w;
    logic                div_busy;
    logic [31:0]         q;
    logic [32:0]         sum_w;
    logic [32:0]         sum_adj;
    logic signed [31:0]  calc_value;
    status_t             calc_status;
    logic                need_div;

    always_comb
    begin
        if (cfg_reg == 8'd0)
        begin
            cap = CW'(1);
        end
        else if (32'(cfg_reg) > MAX_POINTS)
        begin
            cap = CW'(MAX_POINTS);
        end
        else
        begin
            cap = CW'(cfg_reg);
        end
    end

    assign slot_sum  = (CW+1)'(oldest_reg) + (CW+1)'(count_reg);
    assign slot_wrap = (slot_sum >= (CW+1)'(MAX_POINTS)) ?
                       slot_sum - (CW+1)'(MAX_POINTS) : slot_sum;
    assign slot      = slot_wrap[IW-1:0];

    assign scan_issue = active_reg && (rd_idx_reg != count_reg);
    assign scan_done  = active_reg && !scan_issue && !rv_reg;
    assign scan_addr  = rd_idx_reg[IW-1:0];
    assign d          = (list_reg == LIST_OBS) ? sobs_q : sfcst_q;

    always_comb
    begin
        case (op_reg)
            OP_REMOVE: key = (list_reg == LIST_OBS) ? ring_obs_q : ring_fcst_q;
            OP_INSERT: key = (list_reg == LIST_OBS) ? item_reg.obs_value
                                                     : item_reg.fcst_value;
            default:   key = item_reg.fcst_value;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = dj_reg;
        wr_data = d;
        if (rv_reg)
        begin
            case (op_reg)
                OP_REMOVE:
                begin
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = dj_reg - IW'(1);
                        wr_data = d;
                    end
                end
                OP_INSERT:
                begin
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_data = hold_reg;
                    end
                    else if (d > key)
                    begin
                        wr_en   = 1'b1;
                        wr_data = key;
                    end
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        else if (scan_done && op_reg == OP_INSERT)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IW-1:0];
            wr_data = found_reg ? hold_reg : key;
        end
    end

    assign last_idx   = IW'(count_reg - CW'(1));
    assign a0         = !found_reg ? last_idx :
                        (fi_reg == '0) ? '0 : fi_reg - IW'(1);
    assign a1         = !found_reg ? last_idx : fi_reg;
    assign sobs_raddr = cmd.ord0 ? a0 : (cmd.ord1 ? a1 : scan_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en && list_reg == LIST_OBS)
        begin
            sobs_mem[wr_addr] <= wr_data;
        end
        sobs_q <= sobs_mem[sobs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && list_reg == LIST_FCST)
        begin
            sfcst_mem[wr_addr] <= wr_data;
        end
        sfcst_q <= sfcst_mem[scan_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            ring_obs[slot]  <= item_reg.obs_value;
            ring_fcst[slot] <= item_reg.fcst_value;
        end
        if (cmd.ring_rd)
        begin
            ring_obs_q  <= ring_obs[oldest_reg];
            ring_fcst_q <= ring_fcst[oldest_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= POINTS_RESET;
            count_reg  <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (cmd.drop)
            begin
                count_reg  <= count_reg - CW'(1);
                oldest_reg <= (32'(oldest_reg) == MAX_POINTS - 1) ? '0
                                                                  : oldest_reg + IW'(1);
            end
            else if (cmd.store)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            rd_idx_reg <= '0;
            rv_reg     <= 1'b0;
            found_reg  <= 1'b0;
            op_reg     <= OP_SEARCH;
            list_reg   <= LIST_OBS;
        end
        else if (cmd.scan_start)
        begin
            active_reg <= 1'b1;
            rd_idx_reg <= '0;
            rv_reg     <= 1'b0;
            found_reg  <= 1'b0;
            op_reg     <= cmd.scan_op;
            list_reg   <= cmd.scan_list;
        end
        else
        begin
            if (scan_done)
            begin
                active_reg <= 1'b0;
            end
            rv_reg <= scan_issue;
            if (scan_issue)
            begin
                rd_idx_reg <= rd_idx_reg + CW'(1);
            end
            if (rv_reg)
            begin
                case (op_reg)
                    OP_REMOVE:
                    begin
                        if (!found_reg && d == key)
                        begin
                            found_reg <= 1'b1;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (found_reg || d > key)
                        begin
                            found_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!found_reg && key < d)
                        begin
                            found_reg <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dj_reg <= scan_addr;
        if (rv_reg && !cmd.scan_start)
        begin
            if (op_reg == OP_INSERT && (found_reg || d > key))
            begin
                hold_reg <= d;
            end
            if (op_reg == OP_SEARCH)
            begin
                prev_reg <= d;
                if (!found_reg && key < d)
                begin
                    fi_reg <= dj_reg;
                    uf_reg <= d;
                    lf_reg <= prev_reg;
                end
            end
        end
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.ord1)
        begin
            lo_reg <= sobs_q;
        end
        if (cmd.ord2)
        begin
            hi_reg <= sobs_q;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_w;
            dneg_reg <= diff[32];
        end
    end

    assign diff   = {hi_reg[31], hi_reg} - {lo_reg[31], lo_reg};
    assign ndiff  = -diff;
    assign mag    = diff[32] ? ndiff[31:0] : diff[31:0];
    assign num_w  = {item_reg.fcst_value[31], item_reg.fcst_value} - {lf_reg[31], lf_reg};
    assign den_w  = {uf_reg[31], uf_reg} - {lf_reg[31], lf_reg};
    assign prod_w = mag * num_w[31:0];

    qmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (den_w[31:0]),
        .busy     (div_busy),
        .quotient (q)
    );

    assign sum_w   = {lo_reg[31], lo_reg} + {hi_reg[31], hi_reg};
    assign sum_adj = sum_w + {32'd0, sum_w[32]};
    assign need_div = found_reg && (fi_reg != '0) && (lf_reg != uf_reg);

    always_comb
    begin
        if (!found_reg)
        begin
            calc_value  = hi_reg;
            calc_status = ST_CLAMP_HI;
        end
        else if (fi_reg == '0)
        begin
            calc_value  = hi_reg;
            calc_status = ST_CLAMP_LO;
        end
        else if (lf_reg == uf_reg)
        begin
            calc_value  = sum_adj[32:1];
            calc_status = ST_EQUAL;
        end
        else
        begin
            calc_value  = dneg_reg ? lo_reg - q : lo_reg + q;
            calc_status = ST_INTERP;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.res_sel)
            RES_STORED:
            begin
                res_value_reg  <= '0;
                res_status_reg <= ST_STORED;
            end
            RES_IGNORED:
            begin
                res_value_reg  <= '0;
                res_status_reg <= ST_IGNORED;
            end
            RES_PASS:
            begin
                res_value_reg  <= item_reg.fcst_value;
                res_status_reg <= ST_PASS;
            end
            RES_CALC:
            begin
                res_value_reg  <= calc_value;
                res_status_reg <= calc_status;
            end
            default:
            begin
                res_value_reg  <= res_value_reg;
            end
        endcase
        if (cmd.emit)
        begin
            out_data_reg.result_value <= res_value_reg;
            out_data_reg.status       <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign stat.is_add    = (item_reg.kind == KIND_ADD);
    assign stat.pair_ok   = item_reg.obs_valid && item_reg.fcst_valid;
    assign stat.corr_pass = (count_reg == '0) || !item_reg.fcst_valid;
    assign stat.need_drop = (count_reg >= cap);
    assign stat.scan_done = scan_done;
    assign stat.need_div  = need_div;
    assign stat.div_busy  = div_busy;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

[hdl/qmc_ctrl.sv]
// ----------------------------------------------------------------------------
// qmc_ctrl: controller of the quantile mapping corrector
// Sequences drops, sorted inserts, the search, the division and the result.
// ----------------------------------------------------------------------------
module qmc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qmc_pkg::dp_stat_t   stat,
    output qmc_pkg::ctrl_cmd_t  cmd
);
    import qmc_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_DECIDE = 18'h00002,
        S_CHECK  = 18'h00004,
        S_RING   = 18'h00008,
        S_RMO    = 18'h00010,
        S_RMF    = 18'h00020,
        S_DROP   = 18'h00040,
        S_INSO   = 18'h00080,
        S_INSF   = 18'h00100,
        S_STORE  = 18'h00200,
        S_SEARCH = 18'h00400,
        S_ORD0   = 18'h00800,
        S_ORD1   = 18'h01000,
        S_ORD2   = 18'h02000,
        S_MUL    = 18'h04000,
        S_DIVS   = 18'h08000,
        S_DIV    = 18'h10000,
        S_EMIT   = 18'h20000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.scan_op   = OP_SEARCH;
        cmd.scan_list = LIST_OBS;
        cmd.res_sel   = RES_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.is_add)
                begin
                    if (stat.pair_ok)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        cmd.res_sel = RES_IGNORED;
                        state_next  = S_EMIT;
                    end
                end
                else if (stat.corr_pass)
                begin
                    cmd.res_sel = RES_PASS;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_op    = OP_SEARCH;
                    cmd.scan_list  = LIST_FCST;
                    state_next     = S_SEARCH;
                end
            end
            S_CHECK:
            begin
                if (stat.need_drop)
                begin
                    cmd.ring_rd = 1'b1;
                    state_next  = S_RING;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_op    = OP_INSERT;
                    cmd.scan_list  = LIST_OBS;
                    state_next     = S_INSO;
                end
            end
            S_RING:
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_op    = OP_REMOVE;
                cmd.scan_list  = LIST_OBS;
                state_next     = S_RMO;
            end
            S_RMO:
            begin
                if (stat.scan_done)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_op    = OP_REMOVE;
                    cmd.scan_list  = LIST_FCST;
                    state_next     = S_RMF;
                end
            end
            S_RMF:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_DROP;
                end
            end
            S_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = S_CHECK;
            end
            S_INSO:
            begin
                if (stat.scan_done)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_op    = OP_INSERT;
                    cmd.scan_list  = LIST_FCST;
                    state_next     = S_INSF;
                end
            end
            S_INSF:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store   = 1'b1;
                cmd.res_sel = RES_STORED;
                state_next  = S_EMIT;
            end
            S_SEARCH:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_ORD0;
                end
            end
            S_ORD0:
            begin
                cmd.ord0   = 1'b1;
                state_next = S_ORD1;
            end
            S_ORD1:
            begin
                cmd.ord1   = 1'b1;
                state_next = S_ORD2;
            end
            S_ORD2:
            begin
                cmd.ord2   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                if (stat.need_div)
                begin
                    state_next = S_DIVS;
                end
                else
                begin
                    cmd.res_sel = RES_CALC;
                    state_next  = S_EMIT;
                end
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.res_sel = RES_CALC;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/quantile_mapping_corrector.sv]
// ----------------------------------------------------------------------------
// quantile_mapping_corrector: sliding-window quantile mapping corrector
// Keeps recent observation and forecast pairs in sorted lists and maps a
// forecast onto the observations by linear interpolation.
//
//   channel   signals                      role
//   in        in_valid, in_ready, in_data  add or correct beat
//   out       out_valid, out_ready, out_data  one result beat per input
//   cfg       cfg_we, cfg_wdata            window size register
//
// One item is in work at a time. A stored pair walks both sorted lists, and
// walks them again to remove each dropped pair; a correction walks the sorted
// forecast list and may run the 64-step divider.
// Reset clears the pair count and the ring pointer; the memories need no clear.
// A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module quantile_mapping_corrector #(
    parameter int MAX_POINTS = qmc_pkg::MAX_POINTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  qmc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output qmc_pkg::out_item_t out_data
);
    import qmc_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    qmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qmc_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[sim/quantile_mapping_corrector_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantile_mapping_corrector_checker: result predictor and comparator
// Watches the input, output and window size ports, keeps its own sliding
// window of pairs with sorted copies, predicts each result beat and compares
// it field by field with the beats that the block returns.
// ----------------------------------------------------------------------------
module quantile_mapping_corrector_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  qmc_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  qmc_pkg::out_item_t out_data,
    output int                 fail_count,
    output int                 pending,
    output int                 corrections_seen,
    output int                 pairs_seen
);
    import qmc_pkg::*;

    localparam int DEPTH = MAX_POINTS_DEF;

    logic [7:0]         window_reg;
    logic signed [31:0] obs_hist [DEPTH];
    logic signed [31:0] fcst_hist [DEPTH];
    logic signed [31:0] obs_order [DEPTH];
    logic signed [31:0] fcst_order [DEPTH];
    int                 held;
    int                 first_slot;
    out_item_t          expected_beats [$];

    function automatic int window_capacity();
        int c;
        c = int'(window_reg);
        if (c < 1) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    task automatic take_out_obs(input logic signed [31:0] v);
        int j;
        j = 0;
        while (j < held && obs_order[j] != v) j++;
        if (j < held)
            for (; j + 1 < held; j++) obs_order[j] = obs_order[j + 1];
    endtask

    task automatic take_out_fcst(input logic signed [31:0] v);
        int j;
        j = 0;
        while (j < held && fcst_order[j] != v) j++;
        if (j < held)
            for (; j + 1 < held; j++) fcst_order[j] = fcst_order[j + 1];
    endtask

    task automatic place_obs(input logic signed [31:0] v);
        int p;
        p = 0;
        while (p < held && obs_order[p] <= v) p++;
        for (int j = held; j > p; j--) obs_order[j] = obs_order[j - 1];
        obs_order[p] = v;
    endtask

    task automatic place_fcst(input logic signed [31:0] v);
        int p;
        p = 0;
        while (p < held && fcst_order[p] <= v) p++;
        for (int j = held; j > p; j--) fcst_order[j] = fcst_order[j - 1];
        fcst_order[p] = v;
    endtask

    task automatic map_forecast(input in_item_t it, output out_item_t r);
        int i;
        int slot;
        longint lo, hi, lf, uf, d, num, den, mag, q;
        r = '0;
        if (it.kind == KIND_ADD) begin
            if (it.obs_valid && it.fcst_valid) begin
                while (held >= window_capacity() && held > 0) begin
                    take_out_obs(obs_hist[first_slot]);
                    take_out_fcst(fcst_hist[first_slot]);
                    held--;
                    first_slot = (first_slot + 1) % DEPTH;
                end
                slot = (first_slot + held) % DEPTH;
                obs_hist[slot] = it.obs_value;
                fcst_hist[slot] = it.fcst_value;
                place_obs(it.obs_value);
                place_fcst(it.fcst_value);
                held++;
                r.status = ST_STORED;
            end else begin
                r.status = ST_IGNORED;
            end
        end else if (held == 0 || !it.fcst_valid) begin
            r.result_value = it.fcst_value;
            r.status = ST_PASS;
        end else begin
            i = 0;
            while (i < held && !(it.fcst_value < fcst_order[i])) i++;
            if (i >= held) begin
                r.result_value = obs_order[held - 1];
                r.status = ST_CLAMP_HI;
            end else if (i == 0) begin
                r.result_value = obs_order[0];
                r.status = ST_CLAMP_LO;
            end else begin
                lo = obs_order[i - 1];
                hi = obs_order[i];
                lf = fcst_order[i - 1];
                uf = fcst_order[i];
                if (lf == uf) begin
                    r.result_value = 32'((lo + hi) / 2);
                    r.status = ST_EQUAL;
                end else begin
                    d = hi - lo;
                    num = longint'(it.fcst_value) - lf;
                    den = uf - lf;
                    mag = d < 0 ? -d : d;
                    q = longint'(64'(unsigned'(64'(mag * num)) / unsigned'(64'(den))));
                    r.result_value = 32'(d < 0 ? lo - q : lo + q);
                    r.status = ST_INTERP;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_item_t r;
        out_item_t want;
        if (!rst_n) begin
            window_reg = POINTS_RESET;
            held = 0;
            first_slot = 0;
            fail_count = 0;
            corrections_seen = 0;
            pairs_seen = 0;
            expected_beats.delete();
        end else begin
            if (cfg_we) window_reg = cfg_wdata;
            if (in_valid && in_ready) begin
                map_forecast(in_data, r);
                expected_beats = {expected_beats, r};
                if (r.status == ST_STORED) pairs_seen++;
                if (in_data.kind != KIND_ADD) corrections_seen++;
            end
            if (out_valid && out_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected: %h", out_data);
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (out_data.result_value !== want.result_value) begin
                        $error("result_value expected %0d actual %0d",
                               want.result_value, out_data.result_value);
                        fail_count++;
                    end
                    if (out_data.status !== want.status) begin
                        $error("status expected %0d actual %0d",
                               want.status, out_data.status);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_beats.size();
    end
endmodule

[sim/quantile_mapping_corrector_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantile_mapping_corrector_tb: stimulus and verdict
// Drives directed and random add and correct beats through several window
// sizes with random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module quantile_mapping_corrector_tb;
    import qmc_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam logic [7:0] SIZES [5] = '{8'd1, 8'd0, 8'd128, 8'd255, 8'd7};

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    int         fail_count;
    int         pending;
    int         corrections_seen;
    int         pairs_seen;
    int         idle_pct;
    int         quiet_cycles;
    int         beats_sent;

    quantile_mapping_corrector dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    quantile_mapping_corrector_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .corrections_seen(corrections_seen),
        .pairs_seen      (pairs_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("quantile_mapping_corrector: mismatch");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_value(input int spread);
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom();
            default: return 32'(int'($urandom_range(2 * spread)) - spread);
        endcase
    endfunction

    task automatic send_beat(input logic k, input logic signed [31:0] ov, input logic ovl,
                             input logic signed [31:0] fv, input logic fvl);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_data <= '{kind: k, obs_value: ov, obs_valid: ovl, fcst_value: fv, fcst_valid: fvl};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_random(input int spread);
        logic k;
        k = ($urandom_range(99) < 45);
        send_beat(k, pick_value(spread), $urandom_range(9) != 0,
                  pick_value(spread), $urandom_range(9) != 0);
    endtask

    task automatic drain_and_set(input logic [7:0] size);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (1200)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        idle_pct = 12;
        beats_sent = 0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(1'b1, 0, 1'b1, 32'sh12345, 1'b1);
        send_beat(1'b0, 32'sh7fffffff, 1'b0, 5, 1'b1);
        send_beat(1'b0, 5, 1'b1, 32'sh80000000, 1'b0);
        send_beat(1'b0, 32'sh80000000, 1'b1, 32'sh80000000, 1'b1);
        send_beat(1'b0, 32'sh7fffffff, 1'b1, 32'sh7fffffff, 1'b1);
        send_beat(1'b0, 100, 1'b1, 100, 1'b1);
        send_beat(1'b0, 200, 1'b1, 100, 1'b1);
        send_beat(1'b0, -300, 1'b1, 50, 1'b1);
        send_beat(1'b1, 0, 1'b0, 32'sh80000000, 1'b1);
        send_beat(1'b1, 0, 1'b1, 32'sh7fffffff, 1'b1);
        send_beat(1'b1, 0, 1'b1, 75, 1'b1);
        send_beat(1'b1, 0, 1'b1, 100, 1'b1);
        send_beat(1'b1, 0, 1'b1, 1000, 1'b1);
        send_beat(1'b1, 0, 1'b1, -1, 1'b1);
        send_beat(1'b1, -1, 1'b1, 32'shdeadbeef, 1'b0);

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase > 0)
                drain_and_set(SIZES[phase - 1]);
            idle_pct = (phase == 2) ? 0 : 12;
            for (int n = 0; n < 300; n++)
                send_random(phase == 3 ? 40 : 4000);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
        $display("Sent %0d beats: %0d pairs stored, %0d corrections,",
                 beats_sent, pairs_seen, corrections_seen);
        $display("with window sizes 100, 1, 0, 128, 255 and 7.");
        if (fail_count == 0)
            $display("quantile_mapping_corrector: match");
        else
            $display("quantile_mapping_corrector: mismatch");
        $finish;
    end
endmodule

[filelist.f]
hdl/qmc_pkg.sv
hdl/qmc_div.sv
hdl/qmc_dp.sv
hdl/qmc_ctrl.sv
hdl/quantile_mapping_corrector.sv
sim/quantile_mapping_corrector_checker.sv
sim/quantile_mapping_corrector_tb.sv
